[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SWM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SWM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/swm_pkg.sv]
`timescale 1ns / 1ps
package swm_pkg;
	localparam int SAMPLE_W = 10;
	localparam int MID_W    = 10;
	localparam int SUM_W    = 11;
	localparam int CFG_W    = 9;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_OLD   = 9'b000000100,
		ST_MOD   = 9'b000001000,
		ST_ADD   = 9'b000010000,
		ST_WRD   = 9'b000100000,
		ST_WUP   = 9'b001000000,
		ST_WDN   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;
endpackage

[design/swm_if.sv]
`timescale 1ns / 1ps
interface swm_in_if;
	import swm_pkg::*;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swm_out_if;
	import swm_pkg::*;
	logic             valid;
	logic             ready;
	logic [MID_W-1:0] lower_middle;
	logic [MID_W-1:0] upper_middle;
	logic [SUM_W-1:0] median_x2;
	modport source (output valid, output lower_middle, output upper_middle,
		output median_x2, input ready);
	modport sink (input valid, input lower_middle, input upper_middle,
		input median_x2, output ready);
endinterface

[design/sliding_window_median.sv]
`timescale 1ns / 1ps
// Running median over the last window_length samples (1..MAX_WINDOW, 0 acts as 1).
// The state that takes an item is followed by one that reads the departing
// sample. Two more states decrement and increment the histogram, unless the
// departing and new samples are equal; before the window is full only the
// increment is done. Each of the lower and upper pointers then confirms its rank
// and walks one bin at a time toward it, each bin read and then stepped. A last
// state loads the output register. Items before the one that fills the window
// give no result. The walk is slow because only one histogram bin can be read
// per cycle. A result waiting on the output holds the next item back. After reset
// and after every window_length write, the histogram is cleared one bin a cycle,
// bins 0 to VALUE_RANGE-1, and no item is taken during that time.
`include "assert_macros.svh"
module sliding_window_median #(
	parameter int VALUE_RANGE = 1024,
	parameter int MAX_WINDOW  = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [swm_pkg::CFG_W-1:0]   cfg_wdata,
	swm_in_if.sink                      samples,
	swm_out_if.source                   medians
);
	import swm_pkg::*;

	localparam int VW = (VALUE_RANGE > 1) ? $clog2(VALUE_RANGE) : 1;
	localparam int LW = $clog2(MAX_WINDOW + 1);
	localparam int HD = (MAX_WINDOW > 1) ? MAX_WINDOW : 2;
	localparam int HW = $clog2(HD);
	localparam int RESET_LEN = (MAX_WINDOW < 3) ? MAX_WINDOW : 3;

	state_t          state_q;
	logic [LW-1:0]   len_q, fill_q;
	logic [HW-1:0]   head_q;
	logic [VW-1:0]   clr_q, s_q, old_q, lp_q, up_q;
	logic [LW-1:0]   lc_q, uc_q;
	logic            full_q, sel_q;
	logic            out_valid_q;
	logic [MID_W-1:0] out_lo_q, out_hi_q;
	logic [SUM_W-1:0] out_sum_q;

	logic            hist_we;
	logic [VW-1:0]   hist_wa, hist_ra;
	logic [LW-1:0]   hist_wd, hist_rd;
	logic [VW-1:0]   dly_rd;
	logic            accept;
	logic [VW-1:0]   s_sat;
	logic [LW-1:0]   len_eff, rank_lo, rank_hi, cur_c, cur_r;
	logic [VW-1:0]   cur_p;
	logic            load_out;

	assign accept = samples.valid && samples.ready;
	assign samples.ready = (state_q == ST_IDLE);

	always_comb begin
		if (32'(samples.sample) >= VALUE_RANGE) begin
			s_sat = VW'(VALUE_RANGE - 1);
		end else begin
			s_sat = VW'(samples.sample);
		end
		if (cfg_wdata == '0) begin
			len_eff = LW'(1);
		end else if (32'(cfg_wdata) > MAX_WINDOW) begin
			len_eff = LW'(MAX_WINDOW);
		end else begin
			len_eff = LW'(cfg_wdata);
		end
	end

	assign rank_lo = LW'(({1'b0, len_q} + 1'b1) >> 1);
	assign rank_hi = LW'((len_q >> 1) + 1'b1);
	assign cur_c   = sel_q ? uc_q : lc_q;
	assign cur_r   = sel_q ? rank_hi : rank_lo;
	assign cur_p   = sel_q ? up_q : lp_q;

	always_comb begin
		hist_we = 1'b0;
		hist_wa = s_q;
		hist_wd = '0;
		hist_ra = cur_p;
		unique case (state_q)
			ST_CLEAR: begin
				hist_we = 1'b1;
				hist_wa = clr_q;
			end
			ST_OLD: begin
				hist_ra = (full_q && dly_rd != s_q) ? dly_rd : s_q;
			end
			ST_MOD: begin
				hist_we = (hist_rd != '0);
				hist_wa = old_q;
				hist_wd = LW'(hist_rd - 1'b1);
				hist_ra = s_q;
			end
			ST_ADD: begin
				hist_we = 1'b1;
				hist_wa = s_q;
				hist_wd = LW'(hist_rd + 1'b1);
			end
			ST_WRD: begin
				hist_ra = (cur_c < cur_r) ? VW'(cur_p + 1'b1) : cur_p;
			end
			default: begin
			end
		endcase
	end

	swm_ram #(.DEPTH(1 << VW), .WIDTH(LW)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
		.re(1'b1), .raddr(hist_ra), .rdata(hist_rd)
	);

	swm_ram #(.DEPTH(HD), .WIDTH(VW)) u_delay (
		.clk(clk), .we(accept), .waddr(head_q), .wdata(s_sat),
		.re(accept), .raddr(head_q), .rdata(dly_rd)
	);

	assign load_out = (state_q == ST_OUT) && (!out_valid_q || medians.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			len_q   <= LW'(RESET_LEN);
			fill_q  <= '0;
			head_q  <= '0;
			clr_q   <= '0;
			lp_q    <= '0;
			up_q    <= '0;
			lc_q    <= '0;
			uc_q    <= '0;
			full_q  <= 1'b0;
			sel_q   <= 1'b0;
		end else if (cfg_we) begin
			state_q <= ST_CLEAR;
			len_q   <= len_eff;
			fill_q  <= '0;
			head_q  <= '0;
			clr_q   <= '0;
			lp_q    <= '0;
			up_q    <= '0;
			lc_q    <= '0;
			uc_q    <= '0;
			full_q  <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= VW'(clr_q + 1'b1);
					if (32'(clr_q) == VALUE_RANGE - 1 || clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						s_q    <= s_sat;
						full_q <= (fill_q == len_q);
						if (fill_q != len_q) begin
							fill_q <= LW'(fill_q + 1'b1);
						end
						if (LW'(head_q) + LW'(1) == len_q) begin
							head_q <= '0;
						end else begin
							head_q <= HW'(head_q + 1'b1);
						end
						state_q <= ST_OLD;
					end
				end
				ST_OLD: begin
					old_q <= dly_rd;
					lc_q <= LW'(lc_q + LW'(s_q <= lp_q) - LW'(full_q && dly_rd <= lp_q));
					uc_q <= LW'(uc_q + LW'(s_q <= up_q) - LW'(full_q && dly_rd <= up_q));
					sel_q <= 1'b0;
					if (!full_q) begin
						state_q <= ST_ADD;
					end else if (dly_rd != s_q) begin
						state_q <= ST_MOD;
					end else begin
						state_q <= ST_WRD;
					end
				end
				ST_MOD: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= (fill_q == len_q) ? ST_WRD : ST_IDLE;
				end
				ST_WRD: begin
					state_q <= (cur_c < cur_r) ? ST_WUP : ST_WDN;
				end
				ST_WUP: begin
					if (sel_q) begin
						up_q <= VW'(up_q + 1'b1);
						uc_q <= LW'(uc_q + hist_rd);
					end else begin
						lp_q <= VW'(lp_q + 1'b1);
						lc_q <= LW'(lc_q + hist_rd);
					end
					state_q <= ST_WRD;
				end
				ST_WDN: begin
					if ({1'b0, cur_c} >= {1'b0, cur_r} + {1'b0, hist_rd}) begin
						if (sel_q) begin
							up_q <= VW'(up_q - 1'b1);
							uc_q <= LW'(uc_q - hist_rd);
						end else begin
							lp_q <= VW'(lp_q - 1'b1);
							lc_q <= LW'(lc_q - hist_rd);
						end
						state_q <= ST_WRD;
					end else if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_WRD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (medians.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_lo_q  <= MID_W'(lp_q);
			out_hi_q  <= MID_W'(up_q);
			out_sum_q <= SUM_W'(SUM_W'(lp_q) + SUM_W'(up_q));
		end
	end

	assign medians.valid        = out_valid_q;
	assign medians.lower_middle = out_lo_q;
	assign medians.upper_middle = out_hi_q;
	assign medians.median_x2    = out_sum_q;

	`SWM_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= len_q, "fill count above window length")
	`SWM_ASSERT_NOW(a_head_bound, 1'b1, LW'(head_q) < len_q, "ring head outside window")
	`SWM_ASSERT_NEXT(a_mid_order, load_out, out_lo_q <= out_hi_q, "lower middle above upper")
	`SWM_ASSERT_NOW(a_walk_full, state_q == ST_WRD, fill_q == len_q, "walk before window full")
endmodule

[design/swm_ram.sv]
`timescale 1ns / 1ps
module swm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
